// File: sv/aho_pkg.sv
// attention heatmap overlay package: shared types and constants
// no dependencies
package aho_pkg;

  localparam int unsigned SUM_W  = 11;
  localparam int unsigned GAIN_W = 17;
  localparam int unsigned GAIN_FRAC = 16;

  typedef enum logic [1:0] {
    OP_LOAD     = 2'd0,
    OP_FINALIZE = 2'd1,
    OP_PIXEL    = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_RUN,
    ST_MAX,
    ST_DIV,
    ST_WR
  } state_t;

  // front-to-back queue entry
  typedef struct packed {
    op_t              op;
    logic [2:0]       head;
    logic [9:0]       patch;
    logic signed [7:0] score;
    logic [7:0]       pixel;
    logic             in_range;
  } cmd_t;

endpackage

// File: sv/aho_front.sv
// front end: accepts items, maps pixel coordinates to patches, queues commands
// depends on aho_pkg
module aho_front #(
  parameter int HEADS = 6,
  parameter int GRID = 16,
  parameter int PATCHES = 256,
  parameter int PATCH_SIZE = 14,
  parameter int IMAGE_SIZE = 224
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_op,
  input  logic [2:0]          in_head,
  input  logic [7:0]          in_patch,
  input  logic signed [7:0]   in_score,
  input  logic [7:0]          in_pixel,
  input  logic [7:0]          in_row,
  input  logic [7:0]          in_col,
  output logic                q_valid,
  input  logic                q_pop,
  output aho_pkg::cmd_t       q_data
);

  localparam int QD = 4;
  localparam int CW = 11;
  // ceil(2^16 / PATCH_SIZE), exact for coordinates below 1024
  localparam int unsigned RECIP = (65536 + PATCH_SIZE - 1) / PATCH_SIZE;

  aho_pkg::cmd_t  mem_r [QD];
  logic [1:0]     wp_r, rp_r;
  logic [2:0]     cnt_r;

  logic [CW-1:0] row_c, col_c, gy, gx;
  logic [CW-1:0] gy_c, gx_c;
  logic [31:0] gy_m, gx_m;
  logic [2*CW-1:0] pidx;
  aho_pkg::cmd_t cmd;
  logic push;

  // coordinate clamp and patch lookup, reciprocal multiply for the divide
  always_comb begin
    row_c = (CW'(in_row) > CW'(IMAGE_SIZE - 1)) ? CW'(IMAGE_SIZE - 1) : CW'(in_row);
    col_c = (CW'(in_col) > CW'(IMAGE_SIZE - 1)) ? CW'(IMAGE_SIZE - 1) : CW'(in_col);
    gy_m = 32'(row_c) * 32'(RECIP);
    gx_m = 32'(col_c) * 32'(RECIP);
    gy = CW'(gy_m >> 16);
    gx = CW'(gx_m >> 16);
    gy_c = (gy > CW'(GRID - 1)) ? CW'(GRID - 1) : gy;
    gx_c = (gx > CW'(GRID - 1)) ? CW'(GRID - 1) : gx;
    pidx = (2*CW)'(gy_c) * (2*CW)'(GRID) + (2*CW)'(gx_c);
    cmd.op = aho_pkg::op_t'(in_op);
    cmd.head = in_head;
    cmd.score = in_score;
    cmd.pixel = in_pixel;
    if (in_op == aho_pkg::OP_PIXEL) begin
      cmd.patch = pidx[9:0];
      cmd.in_range = pidx < (2*CW)'(PATCHES);
    end else begin
      cmd.patch = {2'b00, in_patch};
      cmd.in_range = (32'(in_patch) < PATCHES) && (32'(in_head) < HEADS);
    end
  end

  assign in_ready = (cnt_r != 3'(QD));
  assign push = in_valid && in_ready && (in_op != aho_pkg::OP_NONE);
  assign q_valid = (cnt_r != 3'd0);
  assign q_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 2'd1;
      if (q_pop) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(push) - 3'(q_pop);
    end
  end

endmodule

// File: sv/aho_back.sv
// back end: sum store, gain store, finalize sequencer with serial divider
// depends on aho_pkg
module aho_back #(
  parameter int PATCHES = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [3:0]       gain_mult,
  input  logic             q_valid,
  output logic             q_pop,
  input  aho_pkg::cmd_t    q_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_pixel,
  output logic             out_not_ready,
  output logic             gains_valid
);

  localparam int AW = $clog2(PATCHES);
  localparam int SW = aho_pkg::SUM_W;
  localparam int GW = aho_pkg::GAIN_W;
  localparam int NW = 32; // numerator 2*mult*sum*65536 fits in 32 bits
  localparam int DW = 12;
  localparam logic [5:0] BIT_LOAD = 6'd40;

  logic signed [SW-1:0] sums_r [PATCHES];
  logic [GW-1:0]        gains_r [PATCHES];

  aho_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]   idx_r;
  logic signed [SW-1:0] max_r, rd_sum_r;
  logic [GW-1:0]   rd_gain_r;
  logic            gv_r;
  logic [5:0]      bit_r;
  logic [NW-1:0]   num_r;
  logic [DW+1:0]   rem_r;
  logic [NW-1:0]   quo_r;
  logic            rd_pend_r;
  logic            pix_pend_r, pix_hit_r;
  logic [7:0]      pix_r;
  logic            ov_r;
  logic [7:0]      op_r;
  logic            onr_r;

  logic run_pop;
  logic signed [SW+1:0] acc;
  logic signed [SW-1:0] sat;
  logic [AW-1:0] p_idx;
  logic last;
  logic [DW+1:0] rem_sh, den2;
  logic [GW-1:0] gclamp;
  logic [GW+7:0] prod;
  logic out_free;

  assign p_idx = q_data.patch[AW-1:0];
  assign last = (idx_r == AW'(PATCHES - 1));
  assign out_free = !ov_r || out_ready;
  assign den2 = {1'b0, max_r, 1'b0} + '0;

  // queue pop while running: a load pops on its write cycle, after the read
  always_comb begin
    run_pop = 1'b0;
    if (state_r == aho_pkg::ST_RUN && q_valid) begin
      unique case (q_data.op)
        aho_pkg::OP_LOAD:     run_pop = rd_pend_r;
        aho_pkg::OP_FINALIZE: run_pop = !rd_pend_r && !pix_pend_r;
        aho_pkg::OP_PIXEL:    run_pop = !rd_pend_r && !pix_pend_r && out_free;
        default:              run_pop = !rd_pend_r;
      endcase
    end
  end
  assign q_pop = run_pop;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      aho_pkg::ST_RUN:
        if (run_pop && q_data.op == aho_pkg::OP_FINALIZE) state_nxt = aho_pkg::ST_MAX;
      aho_pkg::ST_MAX:
        if (rd_pend_r && last) state_nxt = aho_pkg::ST_DIV;
      aho_pkg::ST_DIV:
        if (bit_r == 6'd1) state_nxt = aho_pkg::ST_WR;
      aho_pkg::ST_WR:
        state_nxt = last ? aho_pkg::ST_RUN : aho_pkg::ST_DIV;
      default: state_nxt = aho_pkg::ST_RUN;
    endcase
  end

  // held sum for load read-modify-write, divider shift, gain clamp and pixel scaling
  always_comb begin
    acc = (q_data.head == 3'd0) ? (SW+2)'(q_data.score)
                                : (SW+2)'(rd_sum_r) + (SW+2)'(q_data.score);
    if (acc > (SW+2)'(1023)) sat = SW'(1023);
    else if (acc < -(SW+2)'(1024)) sat = SW'(-1024);
    else sat = SW'(acc);
    rem_sh = {rem_r[DW:0], num_r[NW-1]};
    gclamp = (quo_r > NW'(65536)) ? GW'(65536) : GW'(quo_r);
    prod = (GW+8)'(pix_r) * (GW+8)'(rd_gain_r) + (GW+8)'(32768);
  end

  // memories
  always_ff @(posedge clk) begin
    rd_sum_r <= sums_r[(state_r == aho_pkg::ST_RUN) ? p_idx : idx_r];
    rd_gain_r <= gains_r[p_idx];
    if (state_r == aho_pkg::ST_RUN && rd_pend_r && q_data.in_range)
      sums_r[p_idx] <= sat;
    if (state_r == aho_pkg::ST_WR)
      gains_r[idx_r] <= (max_r > 0 && rd_sum_r > 0) ? gclamp : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= aho_pkg::ST_RUN;
      idx_r <= '0;
      max_r <= '0;
      gv_r <= 1'b0;
      bit_r <= '0;
      rd_pend_r <= 1'b0;
      pix_pend_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ov_r && out_ready) ov_r <= 1'b0;
      unique case (state_r)
        aho_pkg::ST_RUN: begin
          // load: the sum is read first, then written back and the entry popped with rd_pend_r set
          if (q_valid && q_data.op == aho_pkg::OP_LOAD && !rd_pend_r) rd_pend_r <= 1'b1;
          if (rd_pend_r) rd_pend_r <= 1'b0;
          if (run_pop && q_data.op == aho_pkg::OP_PIXEL)
            pix_pend_r <= 1'b1;
          if (pix_pend_r) begin
            pix_pend_r <= 1'b0;
            ov_r <= 1'b1;
            op_r <= !gv_r ? 8'd0 : (pix_hit_r ? prod[GW+6:16] : 8'd0);
            onr_r <= !gv_r;
          end
          pix_r <= q_data.pixel;
          pix_hit_r <= q_data.in_range;
          if (run_pop && q_data.op == aho_pkg::OP_FINALIZE) begin
            idx_r <= '0;
          end
        end
        aho_pkg::ST_MAX: begin
          // sequential scan: each sum is read, then compared before the next read
          if (!rd_pend_r) begin
            rd_pend_r <= 1'b1;
          end else begin
            max_r <= (idx_r == '0 || rd_sum_r > max_r) ? rd_sum_r : max_r;
            if (last) begin
              idx_r <= '0;
              rd_pend_r <= 1'b0;
              bit_r <= 6'd0;
            end else begin
              idx_r <= idx_r + AW'(1);
              rd_pend_r <= 1'b0;
            end
          end
        end
        aho_pkg::ST_DIV: begin
          // wait for the sum read, then restoring divide
          // (2*num + den) / (2*den), one bit a cycle
          if (bit_r == 6'd0) begin
            bit_r <= BIT_LOAD;
          end else if (bit_r == BIT_LOAD) begin
            num_r <= (NW'(gain_mult) * NW'(rd_sum_r[SW-2:0]) << 17) + NW'(max_r);
            rem_r <= '0;
            quo_r <= '0;
            bit_r <= 6'd32;
          end else begin
            if (rem_sh >= den2) begin
              rem_r <= rem_sh - den2;
              quo_r <= {quo_r[NW-2:0], 1'b1};
            end else begin
              rem_r <= rem_sh;
              quo_r <= {quo_r[NW-2:0], 1'b0};
            end
            num_r <= {num_r[NW-2:0], 1'b0};
            bit_r <= bit_r - 6'd1;
          end
        end
        aho_pkg::ST_WR: begin
          bit_r <= 6'd0;
          if (last) begin
            gv_r <= 1'b1;
            idx_r <= '0;
          end else begin
            idx_r <= idx_r + AW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = ov_r;
  assign out_pixel = op_r;
  assign out_not_ready = onr_r;
  assign gains_valid = gv_r;

endmodule

// File: sv/attention_heatmap_overlay_core.sv
// attention heatmap overlay top level: config register, front end, back end
// depends on aho_pkg, aho_front, aho_back
//
// usage: items enter on in_* (op 0 load score, 1 finalize, 2 scale pixel).
// a pixel request returns one result on out_pixel / out_not_ready, other
// requests return none. gain_mult is written on cfg_*, by the user only while
// idle; the block does not enforce this. when the back end is idle, a pixel
// result goes via the queue, the gain store read and the output register.
// a load occupies the back end for a sum store read then write, a pixel for
// a gain store read then the scaling; the next pixel waits for that scaling.
// a finalize walks the sum store once to find the largest sum, reading then
// comparing each patch, and then for each patch reads its sum, runs a
// one-bit-per-cycle divider and writes the gain.
// a four-entry queue between front and back lets the input keep flowing while
// the back end is busy; when it fills, in_ready drops.
// reset clears control state; gain_mult returns to 2, not_ready is set until
// the first finalize. the stores need no clearing pass.
// when the receiver stalls, the result is held in the output register and the
// back end stops taking new pixels.
module attention_heatmap_overlay_core #(
  parameter int HEADS = 6,
  parameter int GRID = 16,
  parameter int PATCHES = 256,
  parameter int PATCH_SIZE = 14,
  parameter int IMAGE_SIZE = 224
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [3:0]        cfg_gain_mult,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_op,
  input  logic [2:0]        in_head,
  input  logic [7:0]        in_patch,
  input  logic signed [7:0] in_score,
  input  logic [7:0]        in_pixel,
  input  logic [7:0]        in_row,
  input  logic [7:0]        in_col,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_pixel,
  output logic              out_not_ready
);

  logic [3:0] gm_r;
  logic q_valid, q_pop, gv;
  aho_pkg::cmd_t q_data;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) gm_r <= 4'd2;
    else if (cfg_valid) gm_r <= cfg_gain_mult;
  end

  aho_front #(.HEADS(HEADS), .GRID(GRID), .PATCHES(PATCHES),
    .PATCH_SIZE(PATCH_SIZE), .IMAGE_SIZE(IMAGE_SIZE)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_op, .in_head, .in_patch,
    .in_score, .in_pixel, .in_row, .in_col,
    .q_valid, .q_pop, .q_data
  );

  aho_back #(.PATCHES(PATCHES)) u_back (
    .clk, .rst_n, .gain_mult(gm_r), .q_valid, .q_pop, .q_data,
    .out_valid, .out_ready, .out_pixel, .out_not_ready, .gains_valid(gv)
  );

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_nr_gv: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && gv && $past(gv, 4)) |-> !out_not_ready)
    else $error("not_ready after finalize");
  a_gv_stay: assert property (@(posedge clk) disable iff (!rst_n)
    $past(gv) && $past(rst_n) |-> gv) else $error("gains valid dropped");

endmodule

// File: tb/tb_attention_heatmap_overlay_core.sv
// testbench for attention_heatmap_overlay_core: loads, finalizes and pixel
// requests with random gaps and output stalls, checked by a built-in predictor
// depends on aho_pkg and the attention_heatmap_overlay_core rtl
module tb_attention_heatmap_overlay_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPATCH = 256;
  localparam int IMG_MAX = 223;
  localparam int PSIZE = 14;
  localparam int GRID_N = 16;
  localparam int NHEADS = 6;
  localparam int STALL_LIMIT = 60000;

  typedef struct {
    logic [7:0] pix;
    logic       nr;
  } overlay_res_t;

  class overlay_scoreboard;
    int sums[NPATCH];
    int gains[NPATCH];
    bit gains_ok;
    int mult;
    overlay_res_t pending_q[$];
    int errors;

    function new();
      gains_ok = 0;
      mult = 2;
      errors = 0;
    endfunction

    function void note_request(aho_pkg::op_t op, int head, int patch, int score, int pixel,
                               int row, int col);
      int s, mx, rr, cc, gy, gx, gain;
      longint num, q, res;
      overlay_res_t r;
      case (op)
        aho_pkg::OP_LOAD: begin
          if (head < NHEADS && patch < NPATCH) begin
            s = (head == 0) ? score : sums[patch] + score;
            if (s > 1023) s = 1023;
            if (s < -1024) s = -1024;
            sums[patch] = s;
          end
        end
        aho_pkg::OP_FINALIZE: begin
          mx = sums[0];
          foreach (sums[p]) if (sums[p] > mx) mx = sums[p];
          foreach (gains[p]) begin
            gains[p] = 0;
            if (mx > 0 && sums[p] > 0) begin
              num = longint'(mult) * sums[p] * 65536;
              q = (2 * num + mx) / (2 * mx);
              gains[p] = (q > 65536) ? 65536 : int'(q);
            end
          end
          gains_ok = 1;
        end
        aho_pkg::OP_PIXEL: begin
          rr = (row > IMG_MAX) ? IMG_MAX : row;
          cc = (col > IMG_MAX) ? IMG_MAX : col;
          gy = rr / PSIZE;
          gx = cc / PSIZE;
          if (gy > GRID_N - 1) gy = GRID_N - 1;
          if (gx > GRID_N - 1) gx = GRID_N - 1;
          res = 0;
          if (gains_ok) begin
            gain = gains[gy * GRID_N + gx];
            res = (longint'(pixel) * gain + 32768) >>> 16;
            if (res > 255) res = 255;
          end
          r.pix = res[7:0];
          r.nr = !gains_ok;
          pending_q.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [7:0] pix, logic nr);
      overlay_res_t e;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: pixel %0d not_ready %0b", pix, nr);
        return;
      end
      e = pending_q.pop_front();
      if (pix !== e.pix || nr !== e.nr) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected pixel %0d not_ready %0b, got pixel %0d not_ready %0b",
                   e.pix, e.nr, pix, nr);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [3:0] cfg_gain_mult = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] in_op = 0;
  logic [2:0] in_head = 0;
  logic [7:0] in_patch = 0;
  logic signed [7:0] in_score = 0;
  logic [7:0] in_pixel = 0;
  logic [7:0] in_row = 0;
  logic [7:0] in_col = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [7:0] out_pixel;
  logic out_not_ready;

  overlay_scoreboard sb = new();
  int burst_left = 0;
  int idle_cycles = 0;
  logic [9:0] stall_cnt = 0;

  attention_heatmap_overlay_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_gain_mult(cfg_gain_mult),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op), .in_head(in_head),
    .in_patch(in_patch), .in_score(in_score), .in_pixel(in_pixel), .in_row(in_row),
    .in_col(in_col), .out_valid(out_valid), .out_ready(out_ready),
    .out_pixel(out_pixel), .out_not_ready(out_not_ready)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // receiver stall pattern, chosen by bits 8:7 of the free-running stall_cnt
  always @(negedge clk) begin
    stall_cnt <= stall_cnt + 10'd1;
    case (stall_cnt[8:7])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= ($urandom_range(0, 3) != 0);
      2'd2: out_ready <= (stall_cnt[1:0] == 2'd0);
      default: out_ready <= 1'($urandom_range(0, 1));
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_pixel, out_not_ready);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send(aho_pkg::op_t op, int head, int patch, int score, int pixel, int row,
                      int col);
    @(negedge clk);
    if (burst_left == 0) begin
      in_valid = 0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 150 : $urandom_range(1, 24);
    end
    in_op = op;
    in_head = 3'(head);
    in_patch = 8'(patch);
    in_score = 8'(score);
    in_pixel = 8'(pixel);
    in_row = 8'(row);
    in_col = 8'(col);
    in_valid = 1;
    do @(posedge clk); while (!in_ready);
    sb.note_request(op, head, patch, score, pixel, row, col);
    burst_left--;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  // a trailing pixel request proves any finalize ahead of it has finished
  task automatic write_mult(int m);
    send(aho_pkg::OP_PIXEL, 0, 0, 0, 255, 0, 0);
    drain();
    repeat (10) @(posedge clk);
    @(negedge clk);
    cfg_gain_mult = 4'(m);
    cfg_valid = 1;
    do @(posedge clk); while (!cfg_ready);
    sb.mult = m;
    @(negedge clk);
    cfg_valid = 0;
  endtask

  function automatic int rand_score();
    case ($urandom_range(0, 7))
      0: return 127;
      1: return -128;
      2, 3: return int'($urandom_range(0, 255)) - 128;
      default: return $urandom_range(0, 127);
    endcase
  endfunction

  task automatic rand_request(int fin_odds);
    int k;
    k = $urandom_range(0, 99);
    if ($urandom_range(0, fin_odds) == 0)
      send(aho_pkg::OP_FINALIZE, $urandom_range(0, 7), $urandom_range(0, 255), rand_score(),
           $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    else if (k < 2)
      send(aho_pkg::OP_NONE, $urandom_range(0, 7), $urandom_range(0, 255), rand_score(),
           $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    else if (k < 45)
      send(aho_pkg::OP_LOAD,
           ($urandom_range(0, 9) == 0) ? $urandom_range(6, 7) : $urandom_range(0, 5),
           $urandom_range(0, 255), rand_score(), $urandom_range(0, 255), 0, 0);
    else
      send(aho_pkg::OP_PIXEL, $urandom_range(0, 7), $urandom_range(0, 255), rand_score(),
           $urandom_range(0, 255),
           ($urandom_range(0, 7) == 0) ? $urandom_range(224, 255) : $urandom_range(0, 223),
           ($urandom_range(0, 7) == 0) ? $urandom_range(224, 255) : $urandom_range(0, 223));
  endtask

  task automatic fill_sums(bit nonpos);
    for (int p = 0; p < NPATCH; p++)
      send(aho_pkg::OP_LOAD, 0, p, nonpos ? -int'($urandom_range(0, 128)) : rand_score(),
           0, 0, 0);
  endtask

  int mults[7] = '{15, 0, 1, 8, 3, 2, 5};

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // pixels before any finalize, unused op, heads beyond range
    send(aho_pkg::OP_PIXEL, 0, 0, 0, 255, 0, 0);
    send(aho_pkg::OP_PIXEL, 7, 255, -128, 255, 255, 255);
    send(aho_pkg::OP_NONE, 7, 255, 127, 255, 255, 255);
    send(aho_pkg::OP_LOAD, 6, 3, 127, 0, 0, 0);
    send(aho_pkg::OP_LOAD, 7, 4, -128, 0, 0, 0);
    fill_sums(0);
    // saturate one sum high and one low
    for (int i = 0; i < 10; i++) send(aho_pkg::OP_LOAD, 1 + i % 5, 17, 127, 0, 0, 0);
    for (int i = 0; i < 10; i++) send(aho_pkg::OP_LOAD, 1 + i % 5, 34, -128, 0, 0, 0);
    send(aho_pkg::OP_FINALIZE, 0, 0, 0, 0, 0, 0);
    send(aho_pkg::OP_PIXEL, 0, 0, 0, 255, 14, 14 * 3);
    send(aho_pkg::OP_PIXEL, 0, 0, 0, 255, 28, 84);
    send(aho_pkg::OP_PIXEL, 0, 0, 0, 0, 223, 223);
    send(aho_pkg::OP_PIXEL, 0, 0, 0, 128, 224, 0);
    send(aho_pkg::OP_PIXEL, 0, 0, 0, 1, 0, 255);
    drain();

    foreach (mults[i]) begin
      write_mult(mults[i]);
      for (int n = 0; n < 120; n++) rand_request(150);
      send(aho_pkg::OP_FINALIZE, 0, 0, 0, 0, 0, 0);
      for (int n = 0; n < 20; n++) rand_request(1000);
      if (i == 2) drain();
    end

    // largest sum not positive
    write_mult(8);
    fill_sums(1);
    send(aho_pkg::OP_FINALIZE, 0, 0, 0, 0, 0, 0);
    for (int n = 0; n < 30; n++)
      send(aho_pkg::OP_PIXEL, 0, 0, 0, $urandom_range(0, 255), $urandom_range(0, 255),
           $urandom_range(0, 255));

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule

// File: files.f
sv/aho_pkg.sv
sv/aho_front.sv
sv/aho_back.sv
sv/attention_heatmap_overlay_core.sv
tb/tb_attention_heatmap_overlay_core.sv
